/* rtl/core/mhts_pkg.sv */
// Shared types and constants for the mailbox host transaction sequencer.
`default_nettype none

package mhts_pkg;

    // Request kinds on the input channel
    localparam logic [1:0] MODE_REQ    = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;

    // Register offsets from the mailbox base
    localparam logic [2:0] PORT_DATA   = 3'd0;
    localparam logic [2:0] PORT_DUMMY  = 3'd3;
    localparam logic [2:0] PORT_STATUS = 3'd4;

    // Status byte bit positions
    localparam int unsigned ST_OBF_BIT  = 0;
    localparam int unsigned ST_IBF_BIT  = 1;
    localparam int unsigned ST_BUSY_BIT = 2;

    localparam logic [15:0] ADJUST_OFFSET  = 16'h0800;
    localparam logic [19:0] POLL_LIMIT_RST = 20'd200000;

    // Result queue depth; must hold at least the two results of one item
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = QAW + 1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CLR1   = 3'd1,
        PH_RDY1   = 3'd2,
        PH_OBFSET = 3'd3,
        PH_WORD   = 3'd4,
        PH_CLR2   = 3'd5,
        PH_RDY2   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ACT_STATUS  = 3'd0,
        ACT_DUMMY   = 3'd1,
        ACT_WRITE   = 3'd2,
        ACT_READ    = 3'd3,
        ACT_DONE    = 3'd4,
        ACT_TIMEOUT = 3'd5
    } t_action;

    typedef struct packed {
        logic [1:0]  mode;
        logic        is_read;
        logic [15:0] map_address;
        logic [7:0]  write_byte;
        logic [7:0]  status_byte;
        logic [31:0] read_word;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [2:0]  port_offset;
        logic [31:0] out_word;
        logic [7:0]  result_byte;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/mhts_if.sv */
// Valid/ready channel interfaces for the sequencer's item and result beats.
`default_nettype none

interface mhts_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        is_read;
    logic [15:0] map_address;
    logic [7:0]  write_byte;
    logic [7:0]  status_byte;
    logic [31:0] read_word;

    modport source (
        output valid, mode, is_read, map_address, write_byte, status_byte, read_word,
        input  ready
    );
    modport sink (
        input  valid, mode, is_read, map_address, write_byte, status_byte, read_word,
        output ready
    );
endinterface

interface mhts_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [2:0]  port_offset;
    logic [31:0] out_word;
    logic [7:0]  result_byte;
    logic        last;

    modport source (
        output valid, action, port_offset, out_word, result_byte, last,
        input  ready
    );
    modport sink (
        input  valid, action, port_offset, out_word, result_byte, last,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/mailbox_host_transaction_sequencer_unit.sv */
// Mailbox host transaction sequencer: phase machine, poll counter and result queue.
// An item beat is registered in the input stage, then its results are written to the result queue.
// Throughput: one item per cycle while items yield one result each and the result queue has
//   room; two-result items go slower, since the result port moves one beat per cycle.
// Reset (synchronous, active low): phase idle, poll counter and pending fields zero,
//   result queue empty, poll_limit back to 200000.
`default_nettype none

module mailbox_host_transaction_sequencer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [19:0] i_cfg_wdata,
    mhts_item_if.sink        i_item,
    mhts_result_if.source    o_result
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [19:0]            r_poll_limit;
    mhts_pkg::t_phase       r_phase, n_phase;
    logic [19:0]            r_polls_left, n_polls_left;
    logic                   r_pend_is_read, n_pend_is_read;
    logic [11:0]            r_pend_offset, n_pend_offset;
    logic [7:0]             r_pend_byte, n_pend_byte;

    // Input stage: one registered item beat waiting for the queue
    logic                   r_in_vld;
    mhts_pkg::t_item        r_in;

    // Result queue: small circular buffer with two write ports, one read port
    mhts_pkg::t_result      r_q [mhts_pkg::QDEPTH];
    logic [mhts_pkg::QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [mhts_pkg::QCW-1:0] r_count;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic w_fire;       // registered item is processed this cycle
    logic w_pop;        // result beat taken downstream

    // Process only when the queue has room for the worst case of two results
    assign w_fire = r_in_vld &&
                    (r_count <= mhts_pkg::QCW'(mhts_pkg::QDEPTH - 2));
    assign w_pop  = o_result.valid && o_result.ready;

    // Take a new beat whenever the input register is empty or drains now
    assign i_item.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.mode        <= i_item.mode;
            r_in.is_read     <= i_item.is_read;
            r_in.map_address <= i_item.map_address;
            r_in.write_byte  <= i_item.write_byte;
            r_in.status_byte <= i_item.status_byte;
            r_in.read_word   <= i_item.read_word;
        end
    end

    // ---------------------------------------------------------------
    // Status decode
    // ---------------------------------------------------------------
    logic w_obf;
    logic w_dev_ready;  // IBF and BUSY both clear
    logic w_last_poll;  // this failed sample uses up the wait

    assign w_obf       = r_in.status_byte[mhts_pkg::ST_OBF_BIT];
    assign w_dev_ready = !r_in.status_byte[mhts_pkg::ST_IBF_BIT] &&
                         !r_in.status_byte[mhts_pkg::ST_BUSY_BIT];
    assign w_last_poll = (r_polls_left <= 20'd1);

    // ---------------------------------------------------------------
    // Next phase
    // ---------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            unique case (r_in.mode)
                mhts_pkg::MODE_REQ: begin
                    if (r_phase == mhts_pkg::PH_IDLE) n_phase = mhts_pkg::PH_CLR1;
                end
                mhts_pkg::MODE_DATA: begin
                    if (r_phase == mhts_pkg::PH_WORD) n_phase = mhts_pkg::PH_CLR2;
                end
                mhts_pkg::MODE_STATUS: begin
                    unique case (r_phase) inside
                        mhts_pkg::PH_CLR1, mhts_pkg::PH_CLR2: begin
                            if (!w_obf) begin
                                n_phase = (r_phase == mhts_pkg::PH_CLR1) ?
                                          mhts_pkg::PH_RDY1 : mhts_pkg::PH_RDY2;
                            end else if (w_last_poll) begin
                                n_phase = mhts_pkg::PH_IDLE;
                            end
                        end
                        mhts_pkg::PH_RDY1: begin
                            if (w_dev_ready) begin
                                n_phase = r_pend_is_read ?
                                          mhts_pkg::PH_OBFSET : mhts_pkg::PH_CLR2;
                            end else if (w_last_poll) begin
                                n_phase = mhts_pkg::PH_IDLE;
                            end
                        end
                        mhts_pkg::PH_OBFSET: begin
                            if (w_obf) begin
                                n_phase = mhts_pkg::PH_WORD;
                            end else if (w_last_poll) begin
                                n_phase = mhts_pkg::PH_IDLE;
                            end
                        end
                        mhts_pkg::PH_RDY2: begin
                            if (w_dev_ready || w_last_poll) n_phase = mhts_pkg::PH_IDLE;
                        end
                        default: n_phase = r_phase;   // idle or awaiting data word
                    endcase
                end
                default: n_phase = r_phase;           // unused mode code: drop
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Results and datapath state
    // ---------------------------------------------------------------
    mhts_pkg::t_result w_res0, w_res1, w_status_res, w_fail_res;
    logic [1:0]        w_nres;
    logic [15:0]       w_offset_full;
    logic [31:0]       w_cmd_word;
    logic [19:0]       w_fail_polls;

    assign w_offset_full = r_in.map_address - mhts_pkg::ADJUST_OFFSET;

    // Packed command: offset in 19:8, op in 23:20, write byte in 31:24
    assign w_cmd_word = {(r_pend_is_read ? 8'h00 : r_pend_byte),
                         3'b000, r_pend_is_read, r_pend_offset, 8'h00};

    assign w_status_res = '{action: mhts_pkg::ACT_STATUS,
                            port_offset: mhts_pkg::PORT_STATUS,
                            out_word: 32'h0, result_byte: 8'h00, last: 1'b1};

    // A failed sample either polls again or gives up the wait
    assign w_fail_res   = w_last_poll ?
                          mhts_pkg::t_result'{action: mhts_pkg::ACT_TIMEOUT,
                                              port_offset: mhts_pkg::PORT_DATA,
                                              out_word: 32'h0, result_byte: 8'h00,
                                              last: 1'b1} :
                          w_status_res;
    assign w_fail_polls = w_last_poll ? 20'd0 : (r_polls_left - 20'd1);

    always_comb begin
        w_res0         = w_status_res;
        w_res1         = w_status_res;
        w_nres         = 2'd0;
        n_polls_left   = r_polls_left;
        n_pend_is_read = r_pend_is_read;
        n_pend_offset  = r_pend_offset;
        n_pend_byte    = r_pend_byte;
        if (w_fire) begin
            unique case (r_in.mode)
                mhts_pkg::MODE_REQ: begin
                    if (r_phase == mhts_pkg::PH_IDLE) begin
                        n_pend_is_read = r_in.is_read;
                        n_pend_offset  = w_offset_full[11:0];
                        n_pend_byte    = r_in.is_read ? 8'h00 : r_in.write_byte;
                        n_polls_left   = r_poll_limit;
                        w_nres         = 2'd1;
                    end
                end
                mhts_pkg::MODE_DATA: begin
                    if (r_phase == mhts_pkg::PH_WORD) begin
                        // Keep the returned byte for the final done
                        n_pend_byte  = r_in.read_word[31:24];
                        n_polls_left = r_poll_limit;
                        w_nres       = 2'd1;
                    end
                end
                mhts_pkg::MODE_STATUS: begin
                    unique case (r_phase) inside
                        mhts_pkg::PH_CLR1, mhts_pkg::PH_CLR2: begin
                            if (!w_obf) begin
                                n_polls_left = r_poll_limit;
                                w_nres       = 2'd1;
                            end else begin
                                // Flush the stale byte, then poll or time out
                                w_res0 = '{action: mhts_pkg::ACT_DUMMY,
                                           port_offset: mhts_pkg::PORT_DUMMY,
                                           out_word: 32'h0, result_byte: 8'h00,
                                           last: 1'b0};
                                w_res1       = w_fail_res;
                                n_polls_left = w_fail_polls;
                                w_nres       = 2'd2;
                            end
                        end
                        mhts_pkg::PH_RDY1: begin
                            if (w_dev_ready) begin
                                w_res0 = '{action: mhts_pkg::ACT_WRITE,
                                           port_offset: mhts_pkg::PORT_DATA,
                                           out_word: w_cmd_word, result_byte: 8'h00,
                                           last: 1'b0};
                                n_polls_left = r_poll_limit;
                                w_nres       = 2'd2;
                            end else begin
                                w_res0       = w_fail_res;
                                n_polls_left = w_fail_polls;
                                w_nres       = 2'd1;
                            end
                        end
                        mhts_pkg::PH_OBFSET: begin
                            if (w_obf) begin
                                w_res0 = '{action: mhts_pkg::ACT_READ,
                                           port_offset: mhts_pkg::PORT_DATA,
                                           out_word: 32'h0, result_byte: 8'h00,
                                           last: 1'b1};
                            end else begin
                                w_res0       = w_fail_res;
                                n_polls_left = w_fail_polls;
                            end
                            w_nres = 2'd1;
                        end
                        mhts_pkg::PH_RDY2: begin
                            if (w_dev_ready) begin
                                w_res0 = '{action: mhts_pkg::ACT_DONE,
                                           port_offset: mhts_pkg::PORT_DATA,
                                           out_word: 32'h0,
                                           result_byte: r_pend_is_read ? r_pend_byte : 8'h00,
                                           last: 1'b1};
                            end else begin
                                w_res0       = w_fail_res;
                                n_polls_left = w_fail_polls;
                            end
                            w_nres = 2'd1;
                        end
                        default: w_nres = 2'd0;
                    endcase
                end
                default: w_nres = 2'd0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit   <= mhts_pkg::POLL_LIMIT_RST;
            r_phase        <= mhts_pkg::PH_IDLE;
            r_polls_left   <= 20'd0;
            r_pend_is_read <= 1'b0;
            r_pend_offset  <= 12'h000;
            r_pend_byte    <= 8'h00;
        end else begin
            if (i_cfg_we) begin
                r_poll_limit <= i_cfg_wdata;
            end
            r_phase        <= n_phase;
            r_polls_left   <= n_polls_left;
            r_pend_is_read <= n_pend_is_read;
            r_pend_offset  <= n_pend_offset;
            r_pend_byte    <= n_pend_byte;
        end
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_nres != 2'd0) begin
            r_q[r_wr_ptr] <= w_res0;
        end
        if (w_nres == 2'd2) begin
            r_q[r_wr_ptr + mhts_pkg::QAW'(1)] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + mhts_pkg::QAW'(w_nres);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + mhts_pkg::QAW'(1);
            end
            r_count <= r_count + mhts_pkg::QCW'(w_nres) - mhts_pkg::QCW'(w_pop);
        end
    end

    assign o_result.valid       = (r_count != '0);
    assign o_result.action      = r_q[r_rd_ptr].action;
    assign o_result.port_offset = r_q[r_rd_ptr].port_offset;
    assign o_result.out_word    = r_q[r_rd_ptr].out_word;
    assign o_result.result_byte = r_q[r_rd_ptr].result_byte;
    assign o_result.last        = r_q[r_rd_ptr].last;

endmodule

`default_nettype wire

/* tb/sv/mhts_sequence_checker.sv */
// Checker for the mailbox sequencer: watches both channels, predicts result beats, compares.
`timescale 1ns / 100ps

module mhts_sequence_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [19:0] i_cfg_wdata,
    mhts_item_if             items,
    mhts_result_if           results,
    output int               o_fail_count,
    output int               o_outstanding
);
    import mhts_pkg::*;

    // Shadow copy of the sequencer state
    logic [19:0] poll_limit;
    t_phase      seq_phase;
    logic [19:0] polls_left;
    logic        pend_read;
    logic [11:0] pend_offset;
    logic [7:0]  pend_byte;

    t_result     expected_beats[$];
    int          mismatches;

    function automatic void emit(input t_action act, input logic [2:0] port,
                                 input logic [31:0] word, input logic [7:0] rbyte,
                                 input logic fin);
        t_result r;
        r.action      = act;
        r.port_offset = port;
        r.out_word    = word;
        r.result_byte = rbyte;
        r.last        = fin;
        expected_beats.push_back(r);
    endfunction

    // A status sample that did not satisfy the current wait
    function automatic void failed_sample();
        if (polls_left <= 20'd1) begin
            polls_left = '0;
            seq_phase  = PH_IDLE;
            emit(ACT_TIMEOUT, PORT_DATA, '0, '0, 1'b1);
        end else begin
            polls_left = polls_left - 20'd1;
            emit(ACT_STATUS, PORT_STATUS, '0, '0, 1'b1);
        end
    endfunction

    // Advance the shadow sequencer by one item beat and queue what it emits
    function automatic void sequencer_step(input t_item it);
        logic        obf;
        logic        blocked;
        logic [31:0] word;
        obf     = it.status_byte[ST_OBF_BIT];
        blocked = it.status_byte[ST_IBF_BIT] | it.status_byte[ST_BUSY_BIT];
        case (it.mode)
            MODE_REQ: begin
                if (seq_phase == PH_IDLE) begin
                    pend_read   = it.is_read;
                    pend_offset = 12'(it.map_address - ADJUST_OFFSET);
                    pend_byte   = it.is_read ? 8'h00 : it.write_byte;
                    seq_phase   = PH_CLR1;
                    polls_left  = poll_limit;
                    emit(ACT_STATUS, PORT_STATUS, '0, '0, 1'b1);
                end
            end
            MODE_DATA: begin
                if (seq_phase == PH_WORD) begin
                    pend_byte  = it.read_word[31:24];
                    seq_phase  = PH_CLR2;
                    polls_left = poll_limit;
                    emit(ACT_STATUS, PORT_STATUS, '0, '0, 1'b1);
                end
            end
            MODE_STATUS: begin
                case (seq_phase)
                    PH_CLR1, PH_CLR2: begin
                        if (!obf) begin
                            seq_phase  = (seq_phase == PH_CLR1) ? PH_RDY1 : PH_RDY2;
                            polls_left = poll_limit;
                            emit(ACT_STATUS, PORT_STATUS, '0, '0, 1'b1);
                        end else begin
                            emit(ACT_DUMMY, PORT_DUMMY, '0, '0, 1'b0);
                            failed_sample();
                        end
                    end
                    PH_RDY1: begin
                        if (!blocked) begin
                            word = {(pend_read ? 8'h00 : pend_byte), 3'b000, pend_read,
                                    pend_offset, 8'h00};
                            emit(ACT_WRITE, PORT_DATA, word, '0, 1'b0);
                            seq_phase  = pend_read ? PH_OBFSET : PH_CLR2;
                            polls_left = poll_limit;
                            emit(ACT_STATUS, PORT_STATUS, '0, '0, 1'b1);
                        end else begin
                            failed_sample();
                        end
                    end
                    PH_OBFSET: begin
                        if (obf) begin
                            seq_phase = PH_WORD;
                            emit(ACT_READ, PORT_DATA, '0, '0, 1'b1);
                        end else begin
                            failed_sample();
                        end
                    end
                    PH_RDY2: begin
                        if (!blocked) begin
                            seq_phase = PH_IDLE;
                            emit(ACT_DONE, PORT_DATA, '0, pend_read ? pend_byte : 8'h00, 1'b1);
                        end else begin
                            failed_sample();
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_item   beat_in;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            poll_limit  = POLL_LIMIT_RST;
            seq_phase   = PH_IDLE;
            polls_left  = '0;
            pend_read   = 1'b0;
            pend_offset = '0;
            pend_byte   = '0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we)
                poll_limit = i_cfg_wdata;
            if (results.valid && results.ready) begin
                got.action      = t_action'(results.action);
                got.port_offset = results.port_offset;
                got.out_word    = results.out_word;
                got.result_byte = results.result_byte;
                got.last        = results.last;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual action %0d port %0d word %08h byte %02h last %0d",
                             $time, got.action, got.port_offset, got.out_word,
                             got.result_byte, got.last);
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: result beat mismatch, expected action %0d port %0d word %08h byte %02h last %0d",
                                 $time, want.action, want.port_offset, want.out_word,
                                 want.result_byte, want.last);
                        $display("%0t:   actual action %0d port %0d word %08h byte %02h last %0d",
                                 $time, got.action, got.port_offset, got.out_word,
                                 got.result_byte, got.last);
                    end
                end
            end
            if (items.valid && items.ready) begin
                beat_in.mode        = items.mode;
                beat_in.is_read     = items.is_read;
                beat_in.map_address = items.map_address;
                beat_in.write_byte  = items.write_byte;
                beat_in.status_byte = items.status_byte;
                beat_in.read_word   = items.read_word;
                sequencer_step(beat_in);
            end
        end
        o_outstanding <= expected_beats.size();
        o_fail_count  <= mismatches;
    end

endmodule

/* tb/sv/tb_mailbox_host_transaction_sequencer_unit.sv */
// Testbench top for the mailbox host transaction sequencer: stimulus, result sink, verdict.
`timescale 1ns / 100ps

module tb_mailbox_host_transaction_sequencer_unit;
    import mhts_pkg::*;

    // Mode code the block must drop
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Idle share of each side, in percent
    localparam int unsigned IDLE_PCT = 13;
    // Cycles the result sink refuses beats in its one long hold-off
    localparam int RX_HOLD_CYCLES = 150;
    // Cycles to let pass after the last expected beat; dropped items leave no trace
    localparam int SETTLE_CYCLES = 8;
    // Successful items per poll_limit setting
    localparam int BEATS_PER_SETTING = 300;
    localparam int NUM_SETTINGS = 7;

    typedef enum logic [1:0] {
        WAIT_OBF_CLEAR,
        WAIT_NOT_BUSY,
        WAIT_OBF_SET
    } t_wait_kind;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [19:0] cfg_wdata;

    int          fail_count;
    int          outstanding;
    int          useful_beats;
    int          poll_span;
    bit          calm;
    bit          rx_hold_go;

    mhts_item_if   item_ch ();
    mhts_result_if result_ch ();

    mailbox_host_transaction_sequencer_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    mhts_sequence_checker u_sequence_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .items         (item_ch),
        .results       (result_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every field random; callers overwrite what the protocol step needs
    function automatic t_item random_item(input logic [1:0] m);
        t_item it;
        it.mode        = m;
        it.is_read     = 1'($urandom_range(1));
        it.map_address = 16'($urandom);
        it.write_byte  = 8'($urandom);
        it.status_byte = 8'($urandom);
        it.read_word   = $urandom;
        return it;
    endfunction

    // Offer one item beat and hold it until the block takes it. Idle gaps go in
    // front of the beat, so valid only drops between beats, never within one.
    task automatic send_beat(input t_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= it.mode;
        item_ch.is_read     <= it.is_read;
        item_ch.map_address <= it.map_address;
        item_ch.write_byte  <= it.write_byte;
        item_ch.status_byte <= it.status_byte;
        item_ch.read_word   <= it.read_word;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic directed_beat(input logic [1:0] m, input logic rd, input logic [15:0] addr,
                                 input logic [7:0] wb, input logic [7:0] st,
                                 input logic [31:0] word);
        t_item it;
        it.mode        = m;
        it.is_read     = rd;
        it.map_address = addr;
        it.write_byte  = wb;
        it.status_byte = st;
        it.read_word   = word;
        send_beat(it);
    endtask

    // Send a beat the block must drop in its current state: idle drops status and
    // data beats, a running wait drops requests and data, awaiting the data word
    // drops requests and status. The unused mode is dropped everywhere.
    task automatic send_noise(input bit idle, input bit awaiting_word);
        logic [1:0] m;
        do
            m = 2'($urandom_range(3));
        while ((idle && m == MODE_REQ) || (awaiting_word && m == MODE_DATA) ||
               (!idle && !awaiting_word && m == MODE_STATUS));
        send_beat(random_item(m));
    endtask

    // Drive one status wait: a random number of failing samples, then a passing
    // one, unless the fails run out the poll budget first (timeout, back to idle).
    task automatic poll_wait(input t_wait_kind kind, output bit gave_up);
        t_item it;
        int    fails_planned;
        int    fails_sent;
        bit    pass;
        fails_planned = ($urandom_range(99) < 55) ? 0 : int'($urandom_range(5, 1));
        fails_sent    = 0;
        gave_up       = 1'b0;
        do begin
            pass = (fails_sent == fails_planned);
            if ($urandom_range(99) < 4)
                send_noise(1'b0, 1'b0);
            it = random_item(MODE_STATUS);
            case (kind)
                WAIT_OBF_CLEAR: it.status_byte[ST_OBF_BIT] = !pass;
                WAIT_OBF_SET:   it.status_byte[ST_OBF_BIT] = pass;
                default: begin
                    if (pass) begin
                        it.status_byte[ST_IBF_BIT]  = 1'b0;
                        it.status_byte[ST_BUSY_BIT] = 1'b0;
                    end else if (!it.status_byte[ST_IBF_BIT] && !it.status_byte[ST_BUSY_BIT]) begin
                        it.status_byte[$urandom_range(1) ? ST_IBF_BIT : ST_BUSY_BIT] = 1'b1;
                    end
                end
            endcase
            send_beat(it);
            useful_beats++;
            if (!pass) begin
                fails_sent++;
                gave_up = (fails_sent >= poll_span);
            end
        end while (!pass && !gave_up);
    endtask

    // Stop offering, then hold until the checker expects nothing more
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result sink: random back-pressure, one long hold-off on request, none while calm
    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_go && !hold_used) begin
                hold_used = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : stimulus
        logic [19:0] limit_plan [NUM_SETTINGS];
        t_item       req;
        bit          gave_up;
        int          target;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.mode        <= MODE_REQ;
        item_ch.is_read     <= 1'b0;
        item_ch.map_address <= '0;
        item_ch.write_byte  <= '0;
        item_ch.status_byte <= '0;
        item_ch.read_word   <= '0;
        useful_beats = 0;
        poll_span    = int'(POLL_LIMIT_RST);

        // Budgets: widest, one sample, zero (acts as one), tight ones, back to reset
        limit_plan = '{20'hFFFFF, 20'd1, 20'd0, 20'd2, 20'd3,
                       20'($urandom_range(8, 4)), POLL_LIMIT_RST};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: beats dropped while idle, a write to the top address with one
        // failing sample in each acquire wait, then a read of address zero (offset
        // wraps) with an early data word, a failed OBF-set sample and a status
        // beat while the data word is awaited.
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'hFF, 32'h0000_0000);
        directed_beat(MODE_DATA,   1'b1, 16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
        directed_beat(MODE_UNUSED, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        directed_beat(MODE_REQ,    1'b0, 16'hFFFF, 8'hFF, 8'h00, 32'h0000_0000);
        directed_beat(MODE_REQ,    1'b1, ADJUST_OFFSET, 8'h00, 8'h00, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'hFF, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'hFE, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'hFF, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'hF9, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'h00, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'h00, 32'h0000_0000);
        directed_beat(MODE_REQ,    1'b1, 16'h0000, 8'hFF, 8'h00, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'h00, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'h00, 32'h0000_0000);
        directed_beat(MODE_DATA,   1'b0, 16'h0000, 8'h00, 8'h00, 32'h1234_5678);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'hFE, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'h01, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'hFF, 32'h0000_0000);
        directed_beat(MODE_DATA,   1'b0, 16'h0000, 8'h00, 8'h00, 32'hFFFF_FFFF);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'h00, 32'h0000_0000);
        directed_beat(MODE_STATUS, 1'b0, 16'h0000, 8'h00, 8'h00, 32'h0000_0000);

        // Random: whole transactions with random content under each poll budget.
        // Every setting change waits for a fully drained, idle sequencer, which
        // also gives the sender's pause until all results are in.
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain_results();
            cfg_wdata <= limit_plan[s];
            cfg_we    <= 1'b1;
            @(posedge clk);
            cfg_we    <= 1'b0;
            poll_span = (limit_plan[s] == 20'd0) ? 1 : int'(limit_plan[s]);
            // Fill the result queue once with the sink held off; run one setting
            // with neither side idling
            if (s == 1)
                rx_hold_go <= 1'b1;
            calm <= (s == 3);

            target = useful_beats + BEATS_PER_SETTING;
            while (useful_beats < target) begin
                if ($urandom_range(99) < 10)
                    send_noise(1'b1, 1'b0);
                req = random_item(MODE_REQ);
                case ($urandom_range(9))
                    0: req.map_address = ADJUST_OFFSET;
                    1: req.map_address = ADJUST_OFFSET - 16'd1;
                    2: req.map_address = 16'hFFFF;
                    3: req.map_address = 16'h0000;
                    default: ;
                endcase
                send_beat(req);
                useful_beats++;
                // Drop out of the script as soon as a wait times out
                poll_wait(WAIT_OBF_CLEAR, gave_up);
                if (!gave_up)
                    poll_wait(WAIT_NOT_BUSY, gave_up);
                if (!gave_up && req.is_read) begin
                    poll_wait(WAIT_OBF_SET, gave_up);
                    if (!gave_up) begin
                        if ($urandom_range(99) < 15)
                            send_noise(1'b0, 1'b1);
                        send_beat(random_item(MODE_DATA));
                        useful_beats++;
                    end
                end
                if (!gave_up)
                    poll_wait(WAIT_OBF_CLEAR, gave_up);
                if (!gave_up)
                    poll_wait(WAIT_NOT_BUSY, gave_up);
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("** mailbox_host_transaction_sequencer_unit: PASSED **");
        end else begin
            $display("** mailbox_host_transaction_sequencer_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("%0t: run did not finish, %0d result beats still expected",
                 $time, outstanding);
        $display("** mailbox_host_transaction_sequencer_unit: FAILED **");
        $finish;
    end

endmodule
